/* design/assert_macros.svh */
// Assertion macros shared by the base-58 encoder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* design/b58_pkg.sv */
// Package for the base-58 encoder: sizes, widths, memory port structs, alphabet.
// Depends on nothing; imported by the encoder top level, digit memory and carry unit.
`default_nettype none

package b58_pkg;

   localparam int MAX_BYTES   = 32;
   localparam int DIGIT_DEPTH = 45;
   localparam int MAX_RESULTS = 45;
   localparam int BASE        = 58;

   localparam int ADDR_W = $clog2(DIGIT_DEPTH);
   localparam int CNT_W  = $clog2(DIGIT_DEPTH + 1);
   localparam int BCNT_W = $clog2(MAX_BYTES + 1);
   localparam int RES_W  = $clog2(MAX_RESULTS + 1);
   localparam int TOT_W  = $clog2(DIGIT_DEPTH + MAX_BYTES + 1);
   localparam int DIG_W  = 6;
   localparam int CARRY_W = 8;
   localparam int CHAR_W = 7;

   localparam logic [CHAR_W-1:0] CHAR_ONE = 7'h31;

   localparam logic [8*BASE-1:0] ALPHABET_STR =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DIG_W-1:0]  data;
   } dram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } dram_rd_type;

   function automatic logic [CHAR_W-1:0] b58_char(input logic [DIG_W-1:0] digit);
      logic [7:0] code;
      code = 8'h31;
      if (int'(digit) < BASE) begin
         code = ALPHABET_STR[8*(BASE-1-int'(digit)) +: 8];
      end
      return code[CHAR_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* design/b58_if.sv */
// Valid/ready channel interfaces of the base-58 encoder: byte input and character output.
// Depends on nothing.
`default_nettype none

interface b58_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface b58_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_code;
   logic       end_of_text;
   logic       overflowed;

   modport source (output valid, output char_code, output end_of_text,
                   output overflowed, input ready);
   modport sink   (input valid, input char_code, input end_of_text,
                   input overflowed, output ready);
endinterface

`default_nettype wire

/* design/base58_encoder.sv */
// Base-58 encoder top level: control sequencer, digit memory, carry unit, output register.
// Depends on b58_pkg, b58_if, b58_digit_ram, b58_divmod and assert_macros.svh.
//
// The block takes a byte string, one byte per transaction with is_last on the final
// byte, and emits its base-58 text, one character per transaction, with a '1' for each
// leading zero byte. For each byte the digit memory is walked one digit per cycle: each
// digit is read, multiplied by 256 plus carry, reduced mod 58 and written back, then
// new top digits, at most two, are appended one a cycle. After the last byte, each
// leading '1' is loaded straight into the output register and each digit takes a
// memory read, then an output load; both wait while the output is full. The digit
// count bounds all reads, so the memory needs no clearing after reset. Bytes past 32
// are dropped and flag overflowed.
`default_nettype none

`include "assert_macros.svh"

module base58_encoder (
   input  wire          clock,
   input  wire          reset,
   b58_req_if.sink      req_chan,
   b58_rsp_if.source    rsp_chan
);
   import b58_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_EXT  = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;
   localparam logic [2:0] ST_LOAD = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   digit_count_ff, digit_count_in;
   logic [BCNT_W-1:0]  zero_run_ff, zero_run_in;
   logic               in_lz_ff, in_lz_in;
   logic [BCNT_W-1:0]  byte_count_ff, byte_count_in;
   logic               ovf_ff, ovf_in;
   logic               last_ff, last_in;
   logic [CARRY_W-1:0] carry_ff, carry_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [RES_W-1:0]   k_ff, k_in;
   logic [RES_W-1:0]   n_ff, n_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_eot_ff, rsp_eot_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   dram_wr_type        ram_wr;
   dram_rd_type        ram_rd;
   logic [DIG_W-1:0]   rd_data;

   logic [DIG_W-1:0]   dm_digit;
   logic [DIG_W-1:0]   dm_digit_out;
   logic [CARRY_W-1:0] dm_carry_out;

   logic               req_fire;
   logic               out_free;
   logic               out_load;
   logic [CHAR_W-1:0]  out_char;
   logic               out_eot;
   logic [TOT_W-1:0]   total;
   logic [RES_W-1:0]   k_next;

   b58_digit_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (rd_data)
   );

   b58_divmod u_divmod (
      .digit     (dm_digit),
      .carry     (carry_ff),
      .digit_out (dm_digit_out),
      .carry_out (dm_carry_out)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign dm_digit       = (state_ff == ST_MUL) ? rd_data : '0;
   assign total          = TOT_W'(zero_run_ff) + TOT_W'(digit_count_ff);
   assign k_next         = k_ff + RES_W'(1);

   always_comb begin
      state_in       = state_ff;
      digit_count_in = digit_count_ff;
      zero_run_in    = zero_run_ff;
      in_lz_in       = in_lz_ff;
      byte_count_in  = byte_count_ff;
      ovf_in         = ovf_ff;
      last_in        = last_ff;
      carry_in       = carry_ff;
      idx_in         = idx_ff;
      k_in           = k_ff;
      n_in           = n_ff;
      ram_wr         = '0;
      ram_rd         = '0;
      out_load       = 1'b0;
      out_char       = CHAR_ONE;
      out_eot        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               last_in = req_chan.is_last;
               if (int'(byte_count_ff) < MAX_BYTES) begin
                  byte_count_in = byte_count_ff + BCNT_W'(1);
                  if (in_lz_ff && (req_chan.data_byte == 8'd0)) begin
                     zero_run_in = zero_run_ff + BCNT_W'(1);
                  end else begin
                     in_lz_in = 1'b0;
                  end
                  carry_in = req_chan.data_byte;
                  idx_in   = '0;
                  if (digit_count_ff == '0) begin
                     state_in = ST_EXT;
                  end else begin
                     ram_rd.en   = 1'b1;
                     ram_rd.addr = '0;
                     state_in    = ST_MUL;
                  end
               end else begin
                  ovf_in   = 1'b1;
                  state_in = ST_FIN;
               end
            end
         end
         ST_MUL: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = idx_ff;
            ram_wr.data = dm_digit_out;
            carry_in    = dm_carry_out;
            if ((CNT_W'(idx_ff) + CNT_W'(1)) < digit_count_ff) begin
               ram_rd.en   = 1'b1;
               ram_rd.addr = idx_ff + ADDR_W'(1);
               idx_in      = idx_ff + ADDR_W'(1);
            end else begin
               state_in = ST_EXT;
            end
         end
         ST_EXT: begin
            if (carry_ff == '0) begin
               state_in = ST_FIN;
            end else if (int'(digit_count_ff) >= DIGIT_DEPTH) begin
               ovf_in   = 1'b1;
               state_in = ST_FIN;
            end else begin
               ram_wr.en      = 1'b1;
               ram_wr.addr    = ADDR_W'(digit_count_ff);
               ram_wr.data    = dm_digit_out;
               digit_count_in = digit_count_ff + CNT_W'(1);
               carry_in       = dm_carry_out;
            end
         end
         ST_FIN: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else begin
               k_in   = '0;
               idx_in = ADDR_W'(digit_count_ff - CNT_W'(1));
               if (total > TOT_W'(MAX_RESULTS)) begin
                  n_in   = RES_W'(MAX_RESULTS);
                  ovf_in = 1'b1;
               end else begin
                  n_in = RES_W'(total);
               end
               if (total == '0) begin
                  digit_count_in = '0;
                  zero_run_in    = '0;
                  in_lz_in       = 1'b1;
                  byte_count_in  = '0;
                  ovf_in         = 1'b0;
                  state_in       = ST_IDLE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (TOT_W'(k_ff) < TOT_W'(zero_run_ff)) begin
               if (out_free) begin
                  out_load = 1'b1;
                  out_char = CHAR_ONE;
                  out_eot  = (k_next == n_ff);
                  k_in     = k_next;
               end
            end else begin
               ram_rd.en   = 1'b1;
               ram_rd.addr = idx_ff;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               out_load = 1'b1;
               out_char = b58_char(rd_data);
               out_eot  = (k_next == n_ff);
               k_in     = k_next;
               idx_in   = idx_ff - ADDR_W'(1);
               state_in = ST_EMIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load && out_eot) begin
         digit_count_in = '0;
         zero_run_in    = '0;
         in_lz_in       = 1'b1;
         byte_count_in  = '0;
         ovf_in         = 1'b0;
         state_in       = ST_IDLE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_eot_in   = rsp_eot_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = out_char;
         rsp_eot_in   = out_eot;
         rsp_ovf_in   = ovf_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         digit_count_ff <= '0;
         zero_run_ff    <= '0;
         in_lz_ff       <= 1'b1;
         byte_count_ff  <= '0;
         ovf_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         digit_count_ff <= digit_count_in;
         zero_run_ff    <= zero_run_in;
         in_lz_ff       <= in_lz_in;
         byte_count_ff  <= byte_count_in;
         ovf_ff         <= ovf_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      carry_ff    <= carry_in;
      idx_ff      <= idx_in;
      k_ff        <= k_in;
      n_ff        <= n_in;
      rsp_char_ff <= rsp_char_in;
      rsp_eot_ff  <= rsp_eot_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.char_code   = rsp_char_ff;
   assign rsp_chan.end_of_text = rsp_eot_ff;
   assign rsp_chan.overflowed  = rsp_ovf_ff;

   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, int'(digit_count_ff) <= DIGIT_DEPTH)
   `ASSERT_IMPLIES(a_mul_in_range, clock, reset, state_ff == ST_MUL, CNT_W'(idx_ff) < digit_count_ff)
   `ASSERT_IMPLIES(a_digit_legal, clock, reset, state_ff == ST_LOAD, int'(rd_data) < BASE)
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_fire, state_ff != ST_IDLE)

endmodule

`default_nettype wire

/* design/b58_digit_ram.sv */
// Digit memory of the base-58 encoder: one write and one read port, registered read data.
// Depends on b58_pkg.
`default_nettype none

module b58_digit_ram (
   input  wire                        clock,
   input  b58_pkg::dram_wr_type       wr,
   input  b58_pkg::dram_rd_type       rd,
   output logic [b58_pkg::DIG_W-1:0]  rd_data
);
   import b58_pkg::*;

   logic [DIG_W-1:0] mem [DIGIT_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule

`default_nettype wire

/* design/b58_divmod.sv */
// One carry step of the encoder: (digit * 256 + carry) split into digit mod 58 and carry.
// Depends on b58_pkg; uses a reciprocal multiply with one correction.
`default_nettype none

module b58_divmod (
   input  wire  [b58_pkg::DIG_W-1:0]   digit,
   input  wire  [b58_pkg::CARRY_W-1:0] carry,
   output logic [b58_pkg::DIG_W-1:0]   digit_out,
   output logic [b58_pkg::CARRY_W-1:0] carry_out
);
   import b58_pkg::*;

   // digit*256 = 4*digit*58 + 24*digit, so only 24*digit + carry needs dividing
   localparam int Y_W    = 11;
   localparam int P_W    = 20;
   localparam int Q_W    = 5;
   localparam int R_W    = 7;
   localparam int RECIP  = 564;
   localparam int RSHIFT = 15;

   logic [Y_W-1:0] y;
   logic [P_W-1:0] prod;
   logic [Q_W-1:0] q0;
   logic [Y_W-1:0] r_wide;
   logic [R_W-1:0] r0;
   logic           fix;

   always_comb begin
      y      = Y_W'({digit, 4'b0000}) + Y_W'({digit, 3'b000}) + Y_W'(carry);
      prod   = P_W'(y) * P_W'(RECIP);
      q0     = prod[RSHIFT +: Q_W];
      r_wide = y - Y_W'(q0) * Y_W'(BASE);
      r0     = r_wide[R_W-1:0];
      fix    = (r0 >= R_W'(BASE));
      digit_out = fix ? DIG_W'(r0 - R_W'(BASE)) : DIG_W'(r0);
      carry_out = CARRY_W'({digit, 2'b00}) + CARRY_W'(q0) + CARRY_W'(fix);
   end

endmodule

`default_nettype wire
